@@ sv/cpbgr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbgr_pkg: shared types and constants for the camera pixel to BGR converter
// Register indexes, format codes, frame size limits, color coefficients and
// helper functions used by the converter datapath.
// ----------------------------------------------------------------------------
package cpbgr_pkg;

    // Channel and size widths
    localparam int CH_W       = 8;
    localparam int SIZE_W     = 13;
    localparam int COL_W      = 12;
    localparam int IDX_W      = 24;
    localparam int CFG_ADDR_W = 8;
    localparam int CFG_DATA_W = 13;

    // Frame size limits
    localparam logic [SIZE_W-1:0] MAX_WIDTH  = 13'd4096;
    localparam logic [SIZE_W-1:0] MAX_HEIGHT = 13'd4096;

    // Register indexes
    localparam logic [CFG_ADDR_W-1:0] REG_PIXEL_FORMAT = 8'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_FLIP_ENABLE  = 8'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_LINE_WIDTH   = 8'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_FRAME_HEIGHT = 8'd3;

    // Source format codes
    localparam logic [1:0] FMT_GRAY = 2'd0;
    localparam logic [1:0] FMT_RGB  = 2'd1;
    localparam logic [1:0] FMT_NV12 = 2'd2;

    // Register reset values
    localparam logic [SIZE_W-1:0] RST_LINE_WIDTH   = 13'd640;
    localparam logic [SIZE_W-1:0] RST_FRAME_HEIGHT = 13'd480;

    // YCbCr fixed point: 16 fraction bits, signed accumulator
    localparam int FRAC_W = 16;
    localparam int ACC_W  = 28;
    localparam logic signed [ACC_W-1:0] K_CR_R = 28'sd91881;
    localparam logic signed [ACC_W-1:0] K_CB_G = 28'sd22553;
    localparam logic signed [ACC_W-1:0] K_CR_G = 28'sd46802;
    localparam logic signed [ACC_W-1:0] K_CB_B = 28'sd116130;
    localparam logic [CH_W:0]           CHROMA_OFS = 9'd128;

    // Live configuration seen by the datapath
    typedef struct packed {
        logic [1:0]        pixel_format;
        logic              flip_enable;
        logic [SIZE_W-1:0] line_width;
        logic [SIZE_W-1:0] frame_height;
    } cfg_t;

    // Position of one pixel in the destination frame
    typedef struct packed {
        logic [COL_W-1:0] dcol;
        logic [COL_W-1:0] row;
        logic             eol;
        logic             eof;
    } pos_t;

    // Map zero to one and cap at the limit
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] r;
        if (v == '0)
            r = SIZE_W'(1);
        else if (v > maxv)
            r = maxv;
        else
            r = v;
        return r;
    endfunction

    // Drop negatives to zero, truncate fraction, saturate to 255
    function automatic logic [CH_W-1:0] sat_channel(input logic signed [ACC_W-1:0] acc);
        logic [CH_W-1:0] r;
        if (acc[ACC_W-1])
            r = '0;
        else if (|acc[ACC_W-2:FRAC_W+CH_W])
            r = '1;
        else
            r = acc[FRAC_W+CH_W-1:FRAC_W];
        return r;
    endfunction

endpackage

@@ sv/cpbgr_ifs.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbgr_ifs: stream and configuration interfaces
// Source pixel stream, BGR result stream and register write channel, each
// with valid/ready handshake.
// ----------------------------------------------------------------------------
interface cpbgr_pix_if
    import cpbgr_pkg::*;
();
    logic            valid;
    logic            ready;
    logic [CH_W-1:0] chan_a;
    logic [CH_W-1:0] chan_b;
    logic [CH_W-1:0] chan_c;

    modport source (output valid, chan_a, chan_b, chan_c, input ready);
    modport sink   (input valid, chan_a, chan_b, chan_c, output ready);
endinterface

interface cpbgr_bgr_if
    import cpbgr_pkg::*;
();
    logic             valid;
    logic             ready;
    logic [CH_W-1:0]  blue_out;
    logic [CH_W-1:0]  green_out;
    logic [CH_W-1:0]  red_out;
    logic [IDX_W-1:0] dest_index;
    logic             end_of_line;
    logic             end_of_frame;

    modport source (output valid, blue_out, green_out, red_out, dest_index,
                    end_of_line, end_of_frame, input ready);
    modport sink   (input valid, blue_out, green_out, red_out, dest_index,
                    end_of_line, end_of_frame, output ready);
endinterface

interface cpbgr_cfg_if
    import cpbgr_pkg::*;
();
    logic                  valid;
    logic                  ready;
    logic [CFG_ADDR_W-1:0] index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

@@ sv/cpbgr_pos.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbgr_pos: raster position tracker
// Holds the column and row counters, gives the destination column, row and
// line/frame end flags for the pixel being accepted, and advances on accept.
// ----------------------------------------------------------------------------
module cpbgr_pos
    import cpbgr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic advance,
    input  cfg_t cfg,
    output pos_t pos
);

    logic [COL_W-1:0]  col_reg, col_next;
    logic [COL_W-1:0]  row_reg, row_next;
    logic [SIZE_W-1:0] w_m1_full, h_m1_full;
    logic [COL_W-1:0]  w_m1, h_m1;
    logic [COL_W-1:0]  col, row;
    logic              eol, eof;

    // Last column and last row of the clamped frame
    assign w_m1_full = clamp_size(cfg.line_width, MAX_WIDTH) - SIZE_W'(1);
    assign h_m1_full = clamp_size(cfg.frame_height, MAX_HEIGHT) - SIZE_W'(1);
    assign w_m1      = w_m1_full[COL_W-1:0];
    assign h_m1      = h_m1_full[COL_W-1:0];

    // Pull a counter past a shrunken size back to the last position
    assign col = (col_reg < w_m1) ? col_reg : w_m1;
    assign row = (row_reg < h_m1) ? row_reg : h_m1;
    assign eol = (col == w_m1);
    assign eof = eol && (row == h_m1);

    // Mirror the column when flip is set
    always_comb
    begin
        pos.dcol = cfg.flip_enable ? (w_m1 - col) : col;
        pos.row  = row;
        pos.eol  = eol;
        pos.eof  = eof;
    end

    // Advance the counters on each accepted word
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (eol)
            begin
                col_next = '0;
                row_next = eof ? '0 : row + COL_W'(1);
            end
            else
            begin
                col_next = col + COL_W'(1);
                row_next = row;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

endmodule

@@ sv/cpbgr_conv.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbgr_conv: pixel color conversion and index computation
// Turns one registered source pixel into B, G, R bytes for the selected
// format and forms row * width + column as the destination index.
// ----------------------------------------------------------------------------
module cpbgr_conv
    import cpbgr_pkg::*;
(
    input  logic [1:0]        pixel_format,
    input  logic [SIZE_W-1:0] width,
    input  logic [CH_W-1:0]   chan_a,
    input  logic [CH_W-1:0]   chan_b,
    input  logic [CH_W-1:0]   chan_c,
    input  pos_t              pos,
    output logic [CH_W-1:0]   blue_out,
    output logic [CH_W-1:0]   green_out,
    output logic [CH_W-1:0]   red_out,
    output logic [IDX_W-1:0]  dest_index
);

    localparam int PROD_W = SIZE_W + COL_W;

    logic signed [CH_W:0]       cb, cr;
    logic signed [ACC_W-1:0]    y_x, cb_x, cr_x;
    logic signed [ACC_W-1:0]    r_acc, g_acc, b_acc;
    logic [PROD_W-1:0]          idx_full;

    // Center chroma around zero and extend to accumulator width
    assign cb   = $signed({1'b0, chan_b} - CHROMA_OFS);
    assign cr   = $signed({1'b0, chan_c} - CHROMA_OFS);
    assign cb_x = $signed({{(ACC_W-CH_W-1){cb[CH_W]}}, cb});
    assign cr_x = $signed({{(ACC_W-CH_W-1){cr[CH_W]}}, cr});
    assign y_x  = $signed({{(ACC_W-CH_W-FRAC_W){1'b0}}, chan_a, {FRAC_W{1'b0}}});

    // Full-range BT.601 sums
    assign r_acc = y_x + K_CR_R * cr_x;
    assign g_acc = y_x - K_CB_G * cb_x - K_CR_G * cr_x;
    assign b_acc = y_x + K_CB_B * cb_x;

    // Select per format; the unused code behaves as RGB
    always_comb
    begin
        case (pixel_format)
            FMT_GRAY:
            begin
                blue_out  = chan_a;
                green_out = chan_a;
                red_out   = chan_a;
            end
            FMT_NV12:
            begin
                blue_out  = sat_channel(b_acc);
                green_out = sat_channel(g_acc);
                red_out   = sat_channel(r_acc);
            end
            default:
            begin
                blue_out  = chan_c;
                green_out = chan_b;
                red_out   = chan_a;
            end
        endcase
    end

    // Destination index, kept to 24 bits
    assign idx_full   = {{SIZE_W{1'b0}}, pos.row} * {{COL_W{1'b0}}, width}
                      + {{SIZE_W{1'b0}}, pos.dcol};
    assign dest_index = idx_full[IDX_W-1:0];

endmodule

@@ sv/camera_pixel_to_bgr_converter.sv @@
`timescale 1ns / 1ps
// Path: an accepted source word passes the input register, then the result register, onto bgr.
// Throughput: one pixel per cycle while bgr is ready; the input register and the result register
// each advance whenever the stage after them is empty or being drained.
// Reset: registers return to RGB, no flip, 640 x 480; counters clear to
// zero and both pipeline stages empty. Configuration is always ready.
// ----------------------------------------------------------------------------
// camera_pixel_to_bgr_converter: camera pixel stream to BGR frame writer
// Accepts gray, RGB or NV12 pixels in raster order and returns one BGR pixel
// per input with its destination index and line/frame end flags.
// ----------------------------------------------------------------------------
module camera_pixel_to_bgr_converter
    import cpbgr_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    cpbgr_pix_if.sink   pix,
    cpbgr_bgr_if.source bgr,
    cpbgr_cfg_if.sink   cfg
);

    // Configuration registers
    logic [1:0]        fmt_reg;
    logic              flip_reg;
    logic [SIZE_W-1:0] width_reg;
    logic [SIZE_W-1:0] height_reg;
    cfg_t              cfg_live;
    logic [SIZE_W-1:0] width_clamped;

    // Input stage
    logic              s1_valid_reg, s1_valid_next;
    logic [CH_W-1:0]   s1_a_reg, s1_b_reg, s1_c_reg;
    pos_t              s1_pos_reg;
    pos_t              pos_cur;

    // Result stage
    logic              out_valid_reg, out_valid_next;
    logic [CH_W-1:0]   blue_reg, green_reg, red_reg;
    logic [IDX_W-1:0]  index_reg;
    logic              eol_reg, eof_reg;
    logic [CH_W-1:0]   blue_c, green_c, red_c;
    logic [IDX_W-1:0]  index_c;

    logic              out_adv;
    logic              in_ready;
    logic              pix_acc;

    // Write configuration registers
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg    <= FMT_RGB;
            flip_reg   <= 1'b0;
            width_reg  <= RST_LINE_WIDTH;
            height_reg <= RST_FRAME_HEIGHT;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                REG_PIXEL_FORMAT: fmt_reg    <= cfg.data[1:0];
                REG_FLIP_ENABLE:  flip_reg   <= cfg.data[0];
                REG_LINE_WIDTH:   width_reg  <= cfg.data[SIZE_W-1:0];
                REG_FRAME_HEIGHT: height_reg <= cfg.data[SIZE_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        cfg_live.pixel_format = fmt_reg;
        cfg_live.flip_enable  = flip_reg;
        cfg_live.line_width   = width_reg;
        cfg_live.frame_height = height_reg;
    end

    assign width_clamped = clamp_size(width_reg, MAX_WIDTH);

    // Pipeline handshake
    assign out_adv   = !out_valid_reg || bgr.ready;
    assign in_ready  = !s1_valid_reg || out_adv;
    assign pix.ready = in_ready;
    assign pix_acc   = pix.valid && in_ready;

    cpbgr_pos u_pos (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (pix_acc),
        .cfg     (cfg_live),
        .pos     (pos_cur)
    );

    // Capture the source word and its position
    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        if (in_ready)
            s1_valid_next = pix.valid;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (pix_acc)
        begin
            s1_a_reg   <= pix.chan_a;
            s1_b_reg   <= pix.chan_b;
            s1_c_reg   <= pix.chan_c;
            s1_pos_reg <= pos_cur;
        end
    end

    cpbgr_conv u_conv (
        .pixel_format (fmt_reg),
        .width        (width_clamped),
        .chan_a       (s1_a_reg),
        .chan_b       (s1_b_reg),
        .chan_c       (s1_c_reg),
        .pos          (s1_pos_reg),
        .blue_out     (blue_c),
        .green_out    (green_c),
        .red_out      (red_c),
        .dest_index   (index_c)
    );

    // Load the result word when the output is free
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_adv)
            out_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (out_adv && s1_valid_reg)
        begin
            blue_reg  <= blue_c;
            green_reg <= green_c;
            red_reg   <= red_c;
            index_reg <= index_c;
            eol_reg   <= s1_pos_reg.eol;
            eof_reg   <= s1_pos_reg.eof;
        end
    end

    assign bgr.valid        = out_valid_reg;
    assign bgr.blue_out     = blue_reg;
    assign bgr.green_out    = green_reg;
    assign bgr.red_out      = red_reg;
    assign bgr.dest_index   = index_reg;
    assign bgr.end_of_line  = eol_reg;
    assign bgr.end_of_frame = eof_reg;

endmodule

@@ sv/cpbgr_checker.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cpbgr_checker: port-level checks for the converter
// Tracks words in flight between the pixel and BGR channels and checks
// occupancy, output hold under stall and readiness when the output is empty.
// ----------------------------------------------------------------------------
module cpbgr_checker
    import cpbgr_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             pix_valid,
    input logic             pix_ready,
    input logic             bgr_valid,
    input logic             bgr_ready,
    input logic [CH_W-1:0]  bgr_blue,
    input logic [CH_W-1:0]  bgr_green,
    input logic [CH_W-1:0]  bgr_red,
    input logic [IDX_W-1:0] bgr_index,
    input logic             bgr_eol,
    input logic             bgr_eof
);

    logic [2:0] flight_reg, flight_next;
    logic       in_acc, out_acc;

    assign in_acc  = pix_valid && pix_ready;
    assign out_acc = bgr_valid && bgr_ready;

    // Count words accepted but not yet delivered
    always_comb
    begin
        flight_next = flight_reg + {2'b00, in_acc} - {2'b00, out_acc};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            flight_reg <= '0;
        else
            flight_reg <= flight_next;
    end

    // At most two words live in the pipeline
    a_flight_max: assert property (@(posedge clk) disable iff (!rst_n)
        flight_reg <= 3'd2)
        else $error("more than two words in flight");

    // A result only appears for an accepted source word
    a_out_has_src: assert property (@(posedge clk) disable iff (!rst_n)
        bgr_valid |-> (flight_reg != 3'd0))
        else $error("result without source word");

    // An empty output lets the next pixel in
    a_ready_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !bgr_valid |-> pix_ready)
        else $error("input stalled with empty output");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (bgr_valid && !bgr_ready) |=>
            (bgr_valid && $stable(bgr_blue) && $stable(bgr_green) && $stable(bgr_red)
             && $stable(bgr_index) && $stable(bgr_eol) && $stable(bgr_eof)))
        else $error("stalled result changed");

endmodule

bind camera_pixel_to_bgr_converter cpbgr_checker u_cpbgr_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .pix_valid (pix.valid),
    .pix_ready (pix.ready),
    .bgr_valid (bgr.valid),
    .bgr_ready (bgr.ready),
    .bgr_blue  (bgr.blue_out),
    .bgr_green (bgr.green_out),
    .bgr_red   (bgr.red_out),
    .bgr_index (bgr.dest_index),
    .bgr_eol   (bgr.end_of_line),
    .bgr_eof   (bgr.end_of_frame)
);

@@ dv/tb_top.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top: self-checking bench for the camera pixel to BGR converter
// Drives source pixel words and register writes, takes each BGR word
// (channels, destination index, line and frame end flags) from the table
// or predicts it from a shadow of the registers and column/row counters,
// and checks it field by field. A directed table, then random frame settings.
// ----------------------------------------------------------------------------
module tb_top;
    import cpbgr_pkg::*;

    localparam int          STALL_LIMIT   = 1000;
    localparam int          RANDOM_PIXELS = 1750;
    localparam int          TABLE_ROWS    = 37;
    localparam logic [1:0]  FMT_UNUSED    = 2'd3;
    localparam int unsigned FULL_SCALE    = 65536;

    // One BGR result word
    typedef struct packed {
        logic [CH_W-1:0]  blue;
        logic [CH_W-1:0]  green;
        logic [CH_W-1:0]  red;
        logic [IDX_W-1:0] dest_index;
        logic             eol;
        logic             eof;
    } bgr_word_t;

    // One row of the directed table: a register write or a pixel word
    typedef struct packed {
        logic                  is_reg;
        logic [CFG_ADDR_W-1:0] reg_index;
        logic [CFG_DATA_W-1:0] reg_data;
        logic [CH_W-1:0]       a;
        logic [CH_W-1:0]       b;
        logic [CH_W-1:0]       c;
        logic                  typed;
        bgr_word_t             want;
    } step_t;

    logic clk;
    logic rst_n;

    cpbgr_pix_if pix_w ();
    cpbgr_bgr_if bgr_w ();
    cpbgr_cfg_if cfg_w ();

    camera_pixel_to_bgr_converter dut (
        .clk   (clk),
        .rst_n (rst_n),
        .pix   (pix_w),
        .bgr   (bgr_w),
        .cfg   (cfg_w)
    );

    // Shadow registers and raster counters of the converter
    logic [1:0]        shadow_format;
    logic              shadow_flip;
    logic [SIZE_W-1:0] shadow_width;
    logic [SIZE_W-1:0] shadow_height;
    int unsigned       col_cnt;
    int unsigned       row_cnt;

    bgr_word_t bgr_expected [$];
    int        error_count;
    int        stall_cycles;
    bit        quiet;

    // Clock
    initial clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int unsigned frame_size(input logic [SIZE_W-1:0] v);
        if (v == '0)
            return 1;
        if (v > 13'd4096)
            return 4096;
        return 32'(v);
    endfunction

    // Drop negatives, truncate the fraction, saturate to 255
    function automatic logic [CH_W-1:0] to_channel(input longint acc);
        if (acc < 0)
            return '0;
        if (acc / FULL_SCALE > 255)
            return 8'hFF;
        return 8'(acc / FULL_SCALE);
    endfunction

    // Compute the BGR word for one source word and advance the counters
    task automatic predict_pixel(input logic [CH_W-1:0] a, b, c, output bgr_word_t w);
        int unsigned wd;
        int unsigned ht;
        int unsigned col;
        int unsigned row;
        int unsigned dcol;
        longint      luma;
        longint      cb;
        longint      cr;
        wd   = frame_size(shadow_width);
        ht   = frame_size(shadow_height);
        col  = (col_cnt < wd - 1) ? col_cnt : wd - 1;
        row  = (row_cnt < ht - 1) ? row_cnt : ht - 1;
        dcol = shadow_flip ? (wd - 1 - col) : col;
        case (shadow_format)
            FMT_GRAY:
            begin
                w.blue  = a;
                w.green = a;
                w.red   = a;
            end
            FMT_NV12:
            begin
                luma    = longint'(a) * FULL_SCALE;
                cb      = longint'(b) - 128;
                cr      = longint'(c) - 128;
                w.red   = to_channel(luma + 91881 * cr);
                w.green = to_channel(luma - 22553 * cb - 46802 * cr);
                w.blue  = to_channel(luma + 116130 * cb);
            end
            default:
            begin
                w.red   = a;
                w.green = b;
                w.blue  = c;
            end
        endcase
        w.dest_index = IDX_W'(row * wd + dcol);
        w.eol        = (col == wd - 1);
        w.eof        = w.eol && (row == ht - 1);
        if (w.eol)
        begin
            col_cnt = 0;
            row_cnt = w.eof ? 0 : row + 1;
        end
        else
        begin
            col_cnt = col + 1;
            row_cnt = row;
        end
    endtask

    task automatic report_mismatch(input string msg);
        $display("MISMATCH at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic check_field(input string name, input logic [IDX_W-1:0] got,
                               input logic [IDX_W-1:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
    endtask

    // Send one pixel word; called at a falling edge, returns at a falling edge
    task automatic send_pixel(input logic [CH_W-1:0] a, b, c, input bit typed,
                              input bgr_word_t typed_word);
        bgr_word_t w;
        while (!quiet && $urandom_range(0, 99) < 9)
        begin
            pix_w.valid = 1'b0;
            @(negedge clk);
        end
        pix_w.valid  = 1'b1;
        pix_w.chan_a = a;
        pix_w.chan_b = b;
        pix_w.chan_c = c;
        do
            @(posedge clk);
        while (!pix_w.ready);
        predict_pixel(a, b, c, w);
        bgr_expected.push_back(typed ? typed_word : w);
        @(negedge clk);
    endtask

    // Write one register; the converter must be idle
    task automatic write_reg(input logic [CFG_ADDR_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_w.valid = 1'b1;
        cfg_w.index = idx;
        cfg_w.data  = data;
        do
            @(posedge clk);
        while (!cfg_w.ready);
        case (idx)
            REG_PIXEL_FORMAT: shadow_format = data[1:0];
            REG_FLIP_ENABLE:  shadow_flip   = data[0];
            REG_LINE_WIDTH:   shadow_width  = data;
            REG_FRAME_HEIGHT: shadow_height = data;
            default: ;
        endcase
        @(negedge clk);
        cfg_w.valid = 1'b0;
    endtask

    // Hold the source and wait for every expected word to arrive
    task automatic drain;
        pix_w.valid = 1'b0;
        while (bgr_expected.size() != 0)
            @(negedge clk);
        repeat (3) @(negedge clk);
    endtask

    function automatic step_t pixel_row(input logic [CH_W-1:0] a, b, c);
        step_t s;
        s   = '0;
        s.a = a;
        s.b = b;
        s.c = c;
        return s;
    endfunction

    function automatic step_t checked_row(input logic [CH_W-1:0] a, b, c,
                                          input logic [CH_W-1:0] blue, green, red,
                                          input logic [IDX_W-1:0] idx,
                                          input logic eol, eof);
        step_t s;
        s       = pixel_row(a, b, c);
        s.typed = 1'b1;
        s.want  = '{blue, green, red, idx, eol, eof};
        return s;
    endfunction

    function automatic step_t reg_row(input logic [CFG_ADDR_W-1:0] idx,
                                      input logic [CFG_DATA_W-1:0] data);
        step_t s;
        s           = '0;
        s.is_reg    = 1'b1;
        s.reg_index = idx;
        s.reg_data  = data;
        return s;
    endfunction

    function automatic logic [CFG_DATA_W-1:0] random_size(input int unsigned small_max);
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 5)
            return '0;
        if (pick < 10)
            return 13'd4096;
        if (pick < 14)
            return CFG_DATA_W'($urandom_range(4097, 8191));
        if (pick < 18)
            return CFG_DATA_W'($urandom_range(1, 8191));
        return CFG_DATA_W'($urandom_range(1, small_max));
    endfunction

    function automatic logic [CH_W-1:0] random_byte;
        int unsigned pick;
        pick = $urandom_range(0, 99);
        if (pick < 12)
            return 8'h00;
        if (pick < 24)
            return 8'hFF;
        return CH_W'($urandom_range(0, 255));
    endfunction

    // Receiver stall pattern
    always @(negedge clk)
        bgr_w.ready <= quiet || ($urandom_range(0, 99) >= 9);

    // Compare each result word with the oldest expectation
    always @(posedge clk)
    begin : check_results
        bgr_word_t want;
        if (rst_n && bgr_w.valid && bgr_w.ready)
        begin
            if (bgr_expected.size() == 0)
                report_mismatch($sformatf("result word with no expectation, index 0x%0h",
                                          bgr_w.dest_index));
            else
            begin
                want = bgr_expected.pop_front();
                check_field("blue_out",     IDX_W'(bgr_w.blue_out),     IDX_W'(want.blue));
                check_field("green_out",    IDX_W'(bgr_w.green_out),    IDX_W'(want.green));
                check_field("red_out",      IDX_W'(bgr_w.red_out),      IDX_W'(want.red));
                check_field("dest_index",   bgr_w.dest_index,           want.dest_index);
                check_field("end_of_line",  IDX_W'(bgr_w.end_of_line),  IDX_W'(want.eol));
                check_field("end_of_frame", IDX_W'(bgr_w.end_of_frame), IDX_W'(want.eof));
            end
        end
    end

    // Watchdog: end the run when no word moves for too long
    always @(posedge clk)
    begin
        if (!rst_n || (pix_w.valid && pix_w.ready) || (bgr_w.valid && bgr_w.ready)
            || (cfg_w.valid && cfg_w.ready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("** camera_pixel_to_bgr_converter: FAILED **");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    // Stimulus
    initial
    begin
        step_t       dir_tbl [TABLE_ROWS];
        int          sent;
        int          phase;
        int unsigned len;
        rst_n         = 1'b0;
        pix_w.valid   = 1'b0;
        pix_w.chan_a  = '0;
        pix_w.chan_b  = '0;
        pix_w.chan_c  = '0;
        cfg_w.valid   = 1'b0;
        cfg_w.index   = '0;
        cfg_w.data    = '0;
        quiet         = 1'b0;
        error_count   = 0;
        shadow_format = FMT_RGB;
        shadow_flip   = 1'b0;
        shadow_width  = RST_LINE_WIDTH;
        shadow_height = RST_FRAME_HEIGHT;
        col_cnt       = 0;
        row_cnt       = 0;

        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        dir_tbl = '{
            // Reset settings: RGB swap, 640 x 480, no flip
            checked_row(8'h11, 8'h22, 8'h33, 8'h33, 8'h22, 8'h11, 24'd0, 1'b0, 1'b0),
            pixel_row(8'hFF, 8'h00, 8'h80),
            pixel_row(8'h00, 8'hFF, 8'h7F),
            // Gray, 2 x 2: column is past the shrunken line and ends it
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_GRAY)),
            reg_row(REG_LINE_WIDTH, 13'd2),
            reg_row(REG_FRAME_HEIGHT, 13'd2),
            checked_row(8'hA5, 8'h5A, 8'hFF, 8'hA5, 8'hA5, 8'hA5, 24'd1, 1'b1, 1'b0),
            pixel_row(8'h00, 8'hFF, 8'hFF),
            checked_row(8'hFF, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'hFF, 24'd3, 1'b1, 1'b1),
            // NV12 with mirroring: chroma extremes and neutral gray
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_NV12)),
            reg_row(REG_FLIP_ENABLE, 13'd1),
            pixel_row(8'h00, 8'h00, 8'h00),
            pixel_row(8'hFF, 8'hFF, 8'hFF),
            checked_row(8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 8'h80, 24'd3, 1'b0, 1'b0),
            pixel_row(8'hFF, 8'h00, 8'h00),
            pixel_row(8'h00, 8'hFF, 8'h00),
            pixel_row(8'hFF, 8'h00, 8'hFF),
            // Unused format code acts as RGB; zero width acts as one
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_UNUSED)),
            reg_row(REG_FLIP_ENABLE, 13'd0),
            reg_row(REG_LINE_WIDTH, 13'd0),
            reg_row(REG_FRAME_HEIGHT, 13'd3),
            checked_row(8'h01, 8'h02, 8'h03, 8'h03, 8'h02, 8'h01, 24'd1, 1'b1, 1'b0),
            pixel_row(8'hFE, 8'h7F, 8'h80),
            pixel_row(8'h55, 8'hAA, 8'h01),
            // Oversized frame saturates to the maximum, mirrored
            reg_row(REG_PIXEL_FORMAT, CFG_DATA_W'(FMT_RGB)),
            reg_row(REG_LINE_WIDTH, 13'd8191),
            reg_row(REG_FRAME_HEIGHT, 13'd8191),
            reg_row(REG_FLIP_ENABLE, 13'd1),
            checked_row(8'h80, 8'h40, 8'h20, 8'h20, 8'h40, 8'h80, 24'd8191, 1'b0, 1'b0),
            pixel_row(8'h7F, 8'hBF, 8'hDF),
            reg_row(REG_FLIP_ENABLE, 13'd0),
            reg_row(REG_LINE_WIDTH, 13'd4096),
            pixel_row(8'h3C, 8'hC3, 8'h66),
            // One-pixel frame: every word ends line and frame
            reg_row(REG_LINE_WIDTH, 13'd1),
            reg_row(REG_FRAME_HEIGHT, 13'd1),
            checked_row(8'hC3, 8'h3C, 8'h99, 8'h99, 8'h3C, 8'hC3, 24'd0, 1'b1, 1'b1),
            pixel_row(8'h10, 8'h20, 8'h30)
        };

        // Walk the directed table
        for (int i = 0; i < TABLE_ROWS; i++)
        begin
            if (dir_tbl[i].is_reg)
            begin
                drain();
                write_reg(dir_tbl[i].reg_index, dir_tbl[i].reg_data);
            end
            else
                send_pixel(dir_tbl[i].a, dir_tbl[i].b, dir_tbl[i].c,
                           dir_tbl[i].typed, dir_tbl[i].want);
        end

        // Random phases: new frame settings, then a burst of pixel words
        sent  = 0;
        phase = 0;
        while (sent < RANDOM_PIXELS)
        begin
            drain();
            quiet = (phase == 3 || phase == 4);
            if ($urandom_range(0, 99) < 70)
                write_reg(REG_PIXEL_FORMAT, ($urandom_range(0, 9) == 0) ?
                          CFG_DATA_W'(FMT_UNUSED) : CFG_DATA_W'($urandom_range(0, 2)));
            if ($urandom_range(0, 99) < 60)
                write_reg(REG_FLIP_ENABLE, CFG_DATA_W'($urandom_range(0, 1)));
            if ($urandom_range(0, 99) < 70)
                write_reg(REG_LINE_WIDTH, random_size(12));
            if ($urandom_range(0, 99) < 70)
                write_reg(REG_FRAME_HEIGHT, random_size(6));
            len = $urandom_range(10, 80);
            repeat (len)
                send_pixel(random_byte(), random_byte(), random_byte(), 1'b0, '0);
            sent += len;
            phase++;
        end

        drain();
        quiet = 1'b0;
        repeat (10) @(negedge clk);
        if (bgr_expected.size() != 0)
            report_mismatch("expected words left over at end of run");
        if (error_count == 0)
            $display("** camera_pixel_to_bgr_converter: PASSED **");
        else
            $display("** camera_pixel_to_bgr_converter: FAILED **");
        $finish;
    end

endmodule

@@ files.f @@
sv/cpbgr_pkg.sv
sv/cpbgr_ifs.sv
sv/cpbgr_pos.sv
sv/cpbgr_conv.sv
sv/camera_pixel_to_bgr_converter.sv
sv/cpbgr_checker.sv
dv/tb_top.sv
